### sv/swoc_pkg.sv
package swoc_pkg;

    // Default ring depth
    localparam int SWOC_DEPTH = 64;

    // Field widths
    localparam int TIME_W = 32;
    localparam int VAL_W  = 32;
    localparam int HITS_W = 32;
    localparam int CFG_W  = 32;
    localparam int CIDX_W = 2;

    // Aggregate mode codes
    localparam logic [1:0] MODE_MEAN = 2'd0;
    localparam logic [1:0] MODE_MIN  = 2'd1;
    localparam logic [1:0] MODE_MAX  = 2'd2;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_AGG_MODE = 2'd0;
    localparam logic [CIDX_W-1:0] REG_REL_GT   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_WIN_LEN  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXP_RD,
        S_EXP_CHK,
        S_AGG,
        S_MEAN,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_EXT_CMP,
        S_STORE,
        S_OVF,
        S_WR,
        S_DONE
    } t_state;

endpackage

### sv/swoc_in_if.sv
interface swoc_in_if;
    logic                              valid;
    logic                              ready;
    logic        [swoc_pkg::TIME_W-1:0] sample_time;
    logic signed [swoc_pkg::VAL_W-1:0]  sample_value;
    logic                              start_req;

    modport source (output valid, output sample_time, output sample_value,
                    output start_req, input ready);
    modport sink   (input valid, input sample_time, input sample_value,
                    input start_req, output ready);
endinterface

### sv/swoc_out_if.sv
interface swoc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         counted;
    logic [swoc_pkg::HITS_W-1:0]  hit_count;
    logic                         window_was_empty;
    logic                         window_overflow;

    modport source (output valid, output counted, output hit_count,
                    output window_was_empty, output window_overflow, input ready);
    modport sink   (input valid, input counted, input hit_count,
                    input window_was_empty, input window_overflow, output ready);
endinterface

### sv/swoc_ring.sv
module swoc_ring #(
    parameter int DEPTH = swoc_pkg::SWOC_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic [swoc_pkg::TIME_W-1:0]       i_wr_time,
    input  logic signed [swoc_pkg::VAL_W-1:0] i_wr_val,
    input  logic [AW-1:0]                     i_rd_addr,
    output logic [swoc_pkg::TIME_W-1:0]       o_rd_time,
    output logic signed [swoc_pkg::VAL_W-1:0] o_rd_val
);
    logic [swoc_pkg::TIME_W-1:0]       r_times [DEPTH];
    logic signed [swoc_pkg::VAL_W-1:0] r_vals  [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_times[i_wr_addr] <= i_wr_time;
            r_vals[i_wr_addr]  <= i_wr_val;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rd_time <= r_times[i_rd_addr];
        o_rd_val  <= r_vals[i_rd_addr];
    end
endmodule

### sv/sliding_window_outlier_counter.sv
// Sliding-window outlier counter.
// Samples enter on i_smp (valid/ready); one result per sample leaves on
// o_res (valid/ready). Config is a plain write port (i_cfg_we, i_cfg_idx,
// i_cfg_data): 0 aggregate mode, 1 relation, 2 window length; write only
// while idle.
// One sample is handled at a time by a sequencer around shared compare
// helpers and one ring memory with a registered read port. Per sample it
// accepts, drops the head entry while it has expired, sets up the
// aggregate and, unless the window is empty, compares with the mean or,
// for min/max, with the extreme from a scan of the stored window (the scan
// dominates); it then evicts if the ring is full, writes and loads a result.
// A result sits in an output register until taken; if the receiver still
// holds the previous one, the sequencer waits at the end before loading,
// and i_smp.ready is low until the sequencer is back at idle.
// Reset (synchronous, active low) empties the window, clears the hit count,
// sets registers to mean / greater / length zero and drops any pending
// result. The ring contents need no clearing.
module sliding_window_outlier_counter #(
    parameter int DEPTH = swoc_pkg::SWOC_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    swoc_in_if.sink                       i_smp,
    swoc_out_if.source                    o_res,
    input  logic                          i_cfg_we,
    input  logic [swoc_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [swoc_pkg::CFG_W-1:0]    i_cfg_data
);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int SUM_W = swoc_pkg::VAL_W + FW;
    localparam int PW    = SUM_W + 1;
    localparam int TW    = swoc_pkg::TIME_W;
    localparam int VW    = swoc_pkg::VAL_W;
    localparam int HW    = swoc_pkg::HITS_W;

    swoc_pkg::t_state r_state, n_state;

    // Config registers
    logic [1:0]    r_mode;
    logic          r_rel_gt;
    logic [TW-1:0] r_wlen;

    // Window control and datapath
    logic [AW-1:0]           r_head, n_head;
    logic [FW-1:0]           r_fill, n_fill;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [HW-1:0]           r_hits, n_hits;
    logic [TW-1:0]           r_t, n_t;
    logic signed [VW-1:0]    r_v, n_v;
    logic [AW-1:0]           r_idx, n_idx;
    logic signed [VW-1:0]    r_ext, n_ext;
    logic signed [PW-1:0]    r_prod, n_prod;
    logic                    r_cnt, n_cnt;
    logic                    r_empty, n_empty;
    logic                    r_ovf, n_ovf;

    // Output register
    logic          r_ovalid;
    logic          r_ocnt;
    logic [HW-1:0] r_ohits;
    logic          r_oempty;
    logic          r_oovf;

    // Memory ports
    logic                 wr_en;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic [TW-1:0]        rd_time;
    logic signed [VW-1:0] rd_val;

    logic in_xfer, out_free, expire, last_scan, is_min, cnt_now, cnt_ext;
    logic signed [VW-1:0] ext_new;
    logic signed [PW-1:0] sum_ext;

    // Ring index: base plus offset, wrapped once (sum stays below 2*DEPTH)
    function automatic logic [AW-1:0] ring_idx(input logic [AW-1:0] base,
                                               input logic [FW-1:0] off);
        logic [FW:0] s;
        s = (FW + 1)'(base) + (FW + 1)'(off);
        if (s >= (FW + 1)'(DEPTH)) begin
            s = s - (FW + 1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    swoc_ring #(.DEPTH(DEPTH)) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_time (r_t),
        .i_wr_val  (r_v),
        .i_rd_addr (rd_addr),
        .o_rd_time (rd_time),
        .o_rd_val  (rd_val)
    );

    assign in_xfer  = i_smp.valid && i_smp.ready;
    assign out_free = !r_ovalid || o_res.ready;
    assign i_smp.ready = (r_state == swoc_pkg::S_IDLE);

    // Shared compare helpers
    assign expire    = (r_t >= rd_time) && ((r_t - rd_time) > r_wlen);
    assign last_scan = ((FW)'(r_idx) + (FW)'(1)) == r_fill;
    assign is_min    = (r_mode == swoc_pkg::MODE_MIN);
    assign sum_ext   = PW'(r_sum);
    assign cnt_now   = r_rel_gt ? (r_prod > sum_ext) : (r_prod < sum_ext);
    assign cnt_ext   = r_rel_gt ? (r_v > r_ext) : (r_v < r_ext);

    always_comb begin
        if (r_idx == '0) begin
            ext_new = rd_val;
        end else if (is_min) begin
            ext_new = (rd_val < r_ext) ? rd_val : r_ext;
        end else begin
            ext_new = (rd_val > r_ext) ? rd_val : r_ext;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swoc_pkg::S_IDLE: begin
                if (in_xfer) n_state = swoc_pkg::S_EXP_RD;
            end
            swoc_pkg::S_EXP_RD: begin
                n_state = (r_fill == '0) ? swoc_pkg::S_AGG : swoc_pkg::S_EXP_CHK;
            end
            swoc_pkg::S_EXP_CHK: begin
                n_state = expire ? swoc_pkg::S_EXP_RD : swoc_pkg::S_AGG;
            end
            swoc_pkg::S_AGG: begin
                if (r_fill == '0) begin
                    n_state = swoc_pkg::S_STORE;
                end else if (r_mode == swoc_pkg::MODE_MEAN) begin
                    n_state = swoc_pkg::S_MEAN;
                end else begin
                    n_state = swoc_pkg::S_SCAN_RD;
                end
            end
            swoc_pkg::S_MEAN:     n_state = swoc_pkg::S_STORE;
            swoc_pkg::S_SCAN_RD:  n_state = swoc_pkg::S_SCAN_CMP;
            swoc_pkg::S_SCAN_CMP: begin
                n_state = last_scan ? swoc_pkg::S_EXT_CMP : swoc_pkg::S_SCAN_RD;
            end
            swoc_pkg::S_EXT_CMP:  n_state = swoc_pkg::S_STORE;
            swoc_pkg::S_STORE: begin
                n_state = (r_fill == FW'(DEPTH)) ? swoc_pkg::S_OVF : swoc_pkg::S_WR;
            end
            swoc_pkg::S_OVF:      n_state = swoc_pkg::S_WR;
            swoc_pkg::S_WR:       n_state = swoc_pkg::S_DONE;
            swoc_pkg::S_DONE: begin
                if (out_free) n_state = swoc_pkg::S_IDLE;
            end
            default:              n_state = swoc_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_head  = r_head;
        n_fill  = r_fill;
        n_sum   = r_sum;
        n_hits  = r_hits;
        n_t     = r_t;
        n_v     = r_v;
        n_idx   = r_idx;
        n_ext   = r_ext;
        n_prod  = r_prod;
        n_cnt   = r_cnt;
        n_empty = r_empty;
        n_ovf   = r_ovf;
        wr_en   = 1'b0;
        wr_addr = ring_idx(r_head, r_fill);
        rd_addr = r_head;
        case (r_state)
            swoc_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_t   = i_smp.sample_time;
                    n_v   = i_smp.sample_value;
                    n_cnt = 1'b0;
                    n_ovf = 1'b0;
                    if (i_smp.start_req) begin
                        n_head = '0;
                        n_fill = '0;
                        n_sum  = '0;
                        n_hits = '0;
                    end
                end
            end
            swoc_pkg::S_EXP_CHK: begin
                if (expire) begin
                    n_sum  = r_sum - SUM_W'(rd_val);
                    n_head = ring_idx(r_head, FW'(1));
                    n_fill = r_fill - FW'(1);
                end
            end
            swoc_pkg::S_AGG: begin
                n_empty = (r_fill == '0);
                n_idx   = '0;
                n_prod  = PW'(r_v) * PW'(r_fill);
            end
            swoc_pkg::S_MEAN: begin
                n_cnt = cnt_now;
                if (cnt_now && (r_hits != '1)) n_hits = r_hits + HW'(1);
            end
            swoc_pkg::S_SCAN_RD: begin
                rd_addr = ring_idx(r_head, FW'(r_idx));
            end
            swoc_pkg::S_SCAN_CMP: begin
                n_ext = ext_new;
                n_idx = r_idx + AW'(1);
            end
            swoc_pkg::S_EXT_CMP: begin
                n_cnt = cnt_ext;
                if (cnt_ext && (r_hits != '1)) n_hits = r_hits + HW'(1);
            end
            swoc_pkg::S_OVF: begin
                n_ovf  = 1'b1;
                n_sum  = r_sum - SUM_W'(rd_val);
                n_head = ring_idx(r_head, FW'(1));
                n_fill = r_fill - FW'(1);
            end
            swoc_pkg::S_WR: begin
                wr_en  = 1'b1;
                n_fill = r_fill + FW'(1);
                n_sum  = r_sum + SUM_W'(r_v);
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swoc_pkg::S_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_hits  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_sum   <= n_sum;
            r_hits  <= n_hits;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_t     <= n_t;
        r_v     <= n_v;
        r_idx   <= n_idx;
        r_ext   <= n_ext;
        r_prod  <= n_prod;
        r_cnt   <= n_cnt;
        r_empty <= n_empty;
        r_ovf   <= n_ovf;
    end

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= swoc_pkg::MODE_MEAN;
            r_rel_gt <= 1'b1;
            r_wlen   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swoc_pkg::REG_AGG_MODE: r_mode   <= i_cfg_data[1:0];
                swoc_pkg::REG_REL_GT:   r_rel_gt <= i_cfg_data[0];
                swoc_pkg::REG_WIN_LEN:  r_wlen   <= i_cfg_data[TW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == swoc_pkg::S_DONE) && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == swoc_pkg::S_DONE) && out_free) begin
            r_ocnt   <= r_cnt;
            r_ohits  <= r_hits;
            r_oempty <= r_empty;
            r_oovf   <= r_ovf;
        end
    end

    assign o_res.valid            = r_ovalid;
    assign o_res.counted          = r_ocnt;
    assign o_res.hit_count        = r_ohits;
    assign o_res.window_was_empty = r_oempty;
    assign o_res.window_overflow  = r_oovf;
endmodule

### dv/swoc_outlier_checker.sv
`timescale 1ns / 100ps

// Watches the sample and result channels, predicts each result and compares.
module swoc_outlier_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    swoc_in_if                 i_smp,
    swoc_out_if                o_res,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    localparam int RING_DEPTH = 64;

    typedef struct packed {
        logic        counted;
        logic [31:0] hit_count;
        logic        window_was_empty;
        logic        window_overflow;
    } outlier_result_t;

    // Predictor state
    logic [1:0]         agg_mode;
    logic               rel_gt;
    logic [31:0]        win_len;
    logic [31:0]        ring_time [RING_DEPTH];
    logic signed [31:0] ring_val [RING_DEPTH];
    int                 head;
    int                 fill;
    longint             win_sum;
    logic [31:0]        hit_total;

    outlier_result_t    expected_results[$];

    // Drop the oldest stored sample
    function automatic void retire_oldest();
        win_sum -= ring_val[head];
        head = (head + 1) % RING_DEPTH;
        fill--;
    endfunction

    // Work out the result for one accepted sample and update the window
    function automatic outlier_result_t predict_outlier(logic [31:0] t,
            logic signed [31:0] v, logic start);
        outlier_result_t    r;
        logic signed [31:0] ext;
        logic signed [31:0] x;
        longint             scaled;
        logic               hit;
        int                 slot;
        hit = 1'b0;
        r = '0;
        if (start) begin
            head = 0;
            fill = 0;
            win_sum = 0;
            hit_total = '0;
        end
        // expiry, time going backward counts as zero difference
        while (fill > 0) begin
            if (t >= ring_time[head] && (t - ring_time[head]) > win_len) begin
                retire_oldest();
            end else begin
                break;
            end
        end
        r.window_was_empty = (fill == 0);
        if (fill != 0) begin
            if (agg_mode == swoc_pkg::MODE_MEAN) begin
                scaled = longint'(v) * fill;
                hit = rel_gt ? (scaled > win_sum) : (scaled < win_sum);
            end else begin
                ext = ring_val[head];
                for (int i = 1; i < fill; i++) begin
                    x = ring_val[(head + i) % RING_DEPTH];
                    if (agg_mode == swoc_pkg::MODE_MIN ? (x < ext) : (x > ext)) ext = x;
                end
                hit = rel_gt ? (v > ext) : (v < ext);
            end
            if (hit && hit_total != 32'hFFFF_FFFF) hit_total++;
        end
        if (fill >= RING_DEPTH) begin
            retire_oldest();
            r.window_overflow = 1'b1;
        end
        slot = (head + fill) % RING_DEPTH;
        ring_time[slot] = t;
        ring_val[slot] = v;
        fill++;
        win_sum += v;
        r.counted = hit;
        r.hit_count = hit_total;
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        outlier_result_t got;
        outlier_result_t exp_r;
        if (!i_rst_n) begin
            agg_mode <= swoc_pkg::MODE_MEAN;
            rel_gt <= 1'b1;
            win_len <= '0;
            head = 0;
            fill = 0;
            win_sum = 0;
            hit_total = '0;
            o_fail_count <= 0;
            expected_results.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    swoc_pkg::REG_AGG_MODE: agg_mode <= i_cfg_data[1:0];
                    swoc_pkg::REG_REL_GT:   rel_gt <= i_cfg_data[0];
                    swoc_pkg::REG_WIN_LEN:  win_len <= i_cfg_data;
                    default: ;
                endcase
            end
            // result transfer
            if (o_res.valid && o_res.ready) begin
                got = {o_res.counted, o_res.hit_count, o_res.window_was_empty,
                       o_res.window_overflow};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: result mismatch, expected c=%b h=%0d e=%b o=%b, actual c=%b h=%0d e=%b o=%b",
                                 $time, exp_r.counted, exp_r.hit_count,
                                 exp_r.window_was_empty, exp_r.window_overflow,
                                 got.counted, got.hit_count,
                                 got.window_was_empty, got.window_overflow);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // sample transfer
            if (i_smp.valid && i_smp.ready)
                expected_results.insert(expected_results.size(),
                    predict_outlier(i_smp.sample_time, i_smp.sample_value,
                                    i_smp.start_req));
        end
    end
endmodule

### dv/sliding_window_outlier_counter_test.sv
`timescale 1ns / 100ps

module sliding_window_outlier_counter_test;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          sample_total;
    logic [31:0] cur_time;

    swoc_in_if  smp_if ();
    swoc_out_if res_if ();

    sliding_window_outlier_counter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_smp(smp_if.sink), .o_res(res_if.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    swoc_outlier_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_smp(smp_if), .o_res(res_if),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Receiver stalls at random per result, with quiet stretches
    initial begin
        int gap;
        res_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            repeat (gap) begin
                res_if.ready <= 1'b0;
                @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!(res_if.valid && res_if.ready)) @(posedge i_clk);
        end
    end

    // One sample transfer after a random gap unless quiet; valid drops only for a gap
    task automatic send_sample(logic [31:0] t, logic [31:0] v, logic start, bit quiet);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.sample_time <= t;
        smp_if.sample_value <= v;
        smp_if.start_req <= start;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        sample_total++;
    endtask

    task automatic stop_sending();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        stop_sending();
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // A random value, often an extreme or a small number
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        bit quiet;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = swoc_pkg::REG_AGG_MODE;
        i_cfg_data = '0;
        smp_if.valid = 1'b0;
        smp_if.sample_time = '0;
        smp_if.sample_value = '0;
        smp_if.start_req = 1'b0;
        sample_total = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, empty window, backward time, all modes
        write_reg(swoc_pkg::REG_WIN_LEN, 32'd10);
        send_sample(32'd0, 32'h7FFF_FFFF, 1'b1, 0);
        send_sample(32'd1, 32'h8000_0000, 1'b0, 0);
        send_sample(32'd2, 32'd5, 1'b0, 0);
        send_sample(32'd1, 32'hFFFF_FFFF, 1'b0, 0);
        send_sample(32'd30, 32'd3, 1'b0, 0);
        send_sample(32'hFFFF_FFFF, 32'd4, 1'b0, 0);
        drain_results();
        for (int m = 0; m < 4; m++) begin
            for (int g = 0; g < 2; g++) begin
                write_reg(swoc_pkg::REG_AGG_MODE, 32'(m));
                write_reg(swoc_pkg::REG_REL_GT, 32'(g));
                send_sample(32'd100, 32'd7, 1'b1, 0);
                send_sample(32'd101, 32'd9, 1'b0, 0);
                send_sample(32'd102, 32'sd1, 1'b0, 0);
                drain_results();
            end
        end
        // overflow: fill the ring past its depth with an infinite window
        write_reg(swoc_pkg::REG_WIN_LEN, 32'hFFFF_FFFF);
        write_reg(swoc_pkg::REG_AGG_MODE, 32'(swoc_pkg::MODE_MEAN));
        write_reg(swoc_pkg::REG_REL_GT, 32'd1);
        cur_time = 0;
        for (int i = 0; i < 70; i++)
            send_sample(cur_time, pick_value(), i == 0, 1);
        drain_results();

        // Random phases with new settings each time
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(swoc_pkg::REG_AGG_MODE, $urandom_range(0, 3));
            write_reg(swoc_pkg::REG_REL_GT, $urandom_range(0, 1));
            case (ph % 4)
                0: write_reg(swoc_pkg::REG_WIN_LEN, 32'd0);
                1: write_reg(swoc_pkg::REG_WIN_LEN, 32'hFFFF_FFFF);
                default: write_reg(swoc_pkg::REG_WIN_LEN, $urandom_range(1, 40));
            endcase
            cur_time = $urandom;
            quiet = (ph == 3);
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(0, 9) == 0) cur_time = $urandom;
                else cur_time = cur_time + $urandom_range(0, 6);
                send_sample(cur_time, pick_value(), $urandom_range(0, 29) == 0, quiet);
                // hold off until the block has caught up
                if (i == 25) begin
                    stop_sending();
                    while (pending != 0) @(posedge i_clk);
                end
            end
            drain_results();
        end

        $display("Covered %0d samples over all aggregate modes, both relations,",
                 sample_total);
        $display("window lengths zero to maximum, ring overflow and restarts.");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Run limit
    initial begin
        #30ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### files.f
sv/swoc_pkg.sv
sv/swoc_in_if.sv
sv/swoc_out_if.sv
sv/swoc_ring.sv
sv/sliding_window_outlier_counter.sv
dv/swoc_outlier_checker.sv
dv/sliding_window_outlier_counter_test.sv
